FILE: hdl/gptpr_pkg.sv
// ----------------------------------------------------------------------------
// gptpr_pkg
// Shared types, constants and helpers of the gameport triplet packet receiver.
// ----------------------------------------------------------------------------
package gptpr_pkg;

    // Buffer capacity in triplets
    localparam int unsigned MAX_TRIPLETS = 512;

    // Timeout constants, in units of port_speed >> SCALE_SHIFT
    localparam logic [11:0] T_START  = 12'd400;
    localparam logic [11:0] T_STROBE = 12'd45;
    localparam logic [11:0] T_GLOBAL = 12'd4000;
    localparam logic [11:0] T_KICK   = 12'd45;
    localparam int unsigned SCALE_SHIFT = 10;

    // Second trigger is held back until the count is within this margin
    localparam logic signed [10:0] END_MARGIN = 11'sd8;

    // Port sample bit positions
    localparam int unsigned CLOCK_POS = 4;
    localparam int unsigned AXIS_POS  = 0;

    // Saturation floor of the down-counters
    localparam logic signed [15:0] TIMER_FLOOR = 16'sh8000;

    // Register indexes
    localparam logic [1:0] REG_PORT_SPEED    = 2'd0;
    localparam logic [1:0] REG_PACKET_LENGTH = 2'd1;
    localparam logic [1:0] REG_ID_SKIP       = 2'd2;

    // Request kinds
    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    // Live configuration, timeouts already scaled
    typedef struct packed {
        logic signed [15:0] to_start;
        logic signed [15:0] to_strobe;
        logic signed [15:0] to_global;
        logic signed [15:0] to_kick;
        logic [9:0]         packet_length;
        logic [8:0]         id_skip;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic [10:0] bits_received;
        logic        finished;
        logic [2:0]  store_triplet;
        logic [8:0]  store_index;
        logic        store_valid;
        logic        trigger_out;
    } t_result;

    // Scale a timeout constant by the port speed
    function automatic logic signed [15:0] scale_timeout(input logic [11:0] k,
                                                         input logic [11:0] speed);
        logic [23:0] prod;
        begin
            prod = 24'(k) * 24'(speed);
            return $signed(16'(prod >> SCALE_SHIFT));
        end
    endfunction

    // Saturating decrement
    function automatic logic signed [15:0] count_down(input logic signed [15:0] t);
        begin
            return (t != TIMER_FLOOR) ? t - 16'sd1 : t;
        end
    endfunction

endpackage

FILE: hdl/gptpr_cfg.sv
// ----------------------------------------------------------------------------
// gptpr_cfg
// Configuration registers; port speed is turned into scaled timeouts on write.
// ----------------------------------------------------------------------------
module gptpr_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data,
    output gptpr_pkg::t_cfg    o_cfg
);
    import gptpr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PORT_SPEED: begin
                    n_cfg.to_start  = scale_timeout(T_START, i_cfg_data);
                    n_cfg.to_strobe = scale_timeout(T_STROBE, i_cfg_data);
                    n_cfg.to_global = scale_timeout(T_GLOBAL, i_cfg_data);
                    n_cfg.to_kick   = scale_timeout(T_KICK, i_cfg_data);
                end
                REG_PACKET_LENGTH: n_cfg.packet_length = i_cfg_data[9:0];
                REG_ID_SKIP:       n_cfg.id_skip       = i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Hold the registers; reset speed is 1024, so each timeout equals its constant
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.to_start      <= $signed(16'(T_START));
            r_cfg.to_strobe     <= $signed(16'(T_STROBE));
            r_cfg.to_global     <= $signed(16'(T_GLOBAL));
            r_cfg.to_kick       <= $signed(16'(T_KICK));
            r_cfg.packet_length <= 10'(MAX_TRIPLETS);
            r_cfg.id_skip       <= 9'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/gptpr_core.sv
// ----------------------------------------------------------------------------
// gptpr_core
// Receiver state and per-sample decision logic; one sample per enabled cycle.
// ----------------------------------------------------------------------------
module gptpr_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_op,
    input  logic [7:0]         i_sample,
    input  gptpr_pkg::t_cfg    i_cfg,
    output gptpr_pkg::t_result o_result
);
    import gptpr_pkg::*;

    t_phase             r_phase,  n_phase;
    logic [7:0]         r_prev,   n_prev;
    logic signed [15:0] r_bit,    n_bit;
    logic signed [15:0] r_glob,   n_glob;
    logic signed [15:0] r_kick,   n_kick;
    logic signed [15:0] r_sched,  n_sched;
    logic               r_pend,   n_pend;
    logic signed [10:0] r_idx,    n_idx;

    logic [9:0]         eff_length;
    logic               clk_rise;
    logic               clk_fall;
    logic               axis_fall;
    logic               check_end;
    t_result            res;

    // Packet length limited to the buffer
    assign eff_length = (i_cfg.packet_length > 10'(MAX_TRIPLETS)) ?
                        10'(MAX_TRIPLETS) : i_cfg.packet_length;

    // Edge detection against the previous sample
    assign clk_rise  = i_sample[CLOCK_POS] & ~r_prev[CLOCK_POS];
    assign clk_fall  = ~i_sample[CLOCK_POS] & r_prev[CLOCK_POS];
    assign axis_fall = ~i_sample[AXIS_POS] & r_prev[AXIS_POS];

    // Next state and result
    always_comb begin
        n_phase   = r_phase;
        n_prev    = r_prev;
        n_bit     = r_bit;
        n_glob    = r_glob;
        n_kick    = r_kick;
        n_sched   = r_sched;
        n_pend    = r_pend;
        n_idx     = r_idx;
        check_end = 1'b0;
        res       = '0;

        if (i_op == OP_START) begin
            // Start a read, abandoning any current one
            res.trigger_out = 1'b1;
            n_idx   = -$signed({2'b00, i_cfg.id_skip});
            n_glob  = (i_cfg.id_skip != 9'd0) ? i_cfg.to_global : 16'sd0;
            n_kick  = (i_cfg.id_skip != 9'd0) ? i_cfg.to_kick : 16'sd0;
            n_bit   = i_cfg.to_start;
            n_pend  = 1'b0;
            n_sched = 16'sd0;
            n_prev  = i_sample;
            n_phase = PH_WAIT;
        end else begin
            case (r_phase)
                PH_WAIT: begin
                    // Wait for the first falling clock edge, or for the start timeout
                    n_prev = i_sample;
                    n_bit  = count_down(r_bit);
                    if (clk_fall || n_bit <= 16'sd0) begin
                        if (n_bit > 16'sd0) begin
                            n_bit = i_cfg.to_strobe;
                        end
                        n_phase   = PH_DATA;
                        check_end = 1'b1;
                    end
                end
                PH_DATA: begin
                    n_prev  = i_sample;
                    n_glob  = count_down(r_glob);
                    n_bit   = count_down(r_bit);
                    n_sched = count_down(r_sched);
                    // Take a triplet on each rising clock edge inside the strobe window
                    if (clk_rise && n_bit > 16'sd0) begin
                        if (r_idx >= 11'sd0) begin
                            res.store_valid   = 1'b1;
                            res.store_index   = r_idx[8:0];
                            res.store_triplet = i_sample[7:5];
                        end
                        n_idx = r_idx + 11'sd1;
                        n_bit = i_cfg.to_strobe;
                    end
                    // Arm the second trigger on the axis falling edge
                    if (r_kick != 16'sd0 && axis_fall) begin
                        n_sched = r_kick;
                        n_kick  = 16'sd0;
                        n_pend  = 1'b1;
                    end
                    // Issue the second trigger and drop the global timeout
                    if (n_pend && n_sched < 16'sd0 && n_idx > -END_MARGIN) begin
                        res.trigger_out = 1'b1;
                        n_bit  = i_cfg.to_start;
                        n_pend = 1'b0;
                        n_glob = 16'sd0;
                    end
                    check_end = 1'b1;
                end
                default: ;
            endcase

            // End the read on timeout or full packet
            if (check_end && !((n_glob > 16'sd0 || n_bit > 16'sd0) &&
                               n_idx < $signed({1'b0, eff_length}))) begin
                res.finished      = 1'b1;
                res.bits_received = n_idx;
                n_phase           = PH_IDLE;
            end
        end
    end

    // Advance state once per processed sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_prev  <= 8'd0;
            r_bit   <= 16'sd0;
            r_glob  <= 16'sd0;
            r_kick  <= 16'sd0;
            r_sched <= 16'sd0;
            r_pend  <= 1'b0;
            r_idx   <= 11'sd0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_prev  <= n_prev;
            r_bit   <= n_bit;
            r_glob  <= n_glob;
            r_kick  <= n_kick;
            r_sched <= n_sched;
            r_pend  <= n_pend;
            r_idx   <= n_idx;
        end
    end

    assign o_result = res;

endmodule

FILE: hdl/gameport_triplet_packet_receiver.sv
// Path: a request is held in the input register, and its result in the result register.
// Throughput: one port sample per cycle unless the output side stalls; the input
//   register holds one more sample while the result register waits.
// Reset: synchronous active-low; the receiver goes idle, timers and count clear,
//   port speed returns to 1024, packet length to 512 and ID skip to zero.
// ----------------------------------------------------------------------------
// gameport_triplet_packet_receiver
// Gameport triplet packet receiver: input register, decision logic, result
// register.
// ----------------------------------------------------------------------------
module gameport_triplet_packet_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    // Sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] port_sample
    input  logic        s_axis_tuser,   // [0] operation
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [0] trigger_out, [1] store_valid,
                                        // [10:2] store_index, [13:11] store_triplet,
                                        // [14] finished, [25:15] bits_received,
                                        // [31:26] zero
);
    import gptpr_pkg::*;

    t_cfg    cfg;
    t_result core_res;

    logic       r_s1_valid;
    logic       r_s1_op;
    logic [7:0] r_s1_sample;
    logic       r_o_valid;
    t_result    r_o_res;
    logic       s1_advance;

    gptpr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Move the held request on when the result register is free
    assign s1_advance    = r_s1_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_advance;

    gptpr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (s1_advance),
        .i_op     (r_s1_op),
        .i_sample (r_s1_sample),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1_op     <= s_axis_tuser;
            r_s1_sample <= s_axis_tdata;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_advance) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_o_res <= core_res;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {6'd0, r_o_res};

endmodule

FILE: test/tb_gameport_triplet_packet_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gameport_triplet_packet_receiver
// Drives port samples into the triplet packet receiver and checks every result
// against a cycle-free prediction of the read: trigger writes, stored triplets
// and the final count. Directed reads cover the edge cases, then random reads
// under changing settings and handshake pressure.
// ----------------------------------------------------------------------------
module tb_gameport_triplet_packet_receiver;
    import gptpr_pkg::*;

    // Prediction of the receiver and store of the results still owed by it
    class triplet_read_scoreboard;
        logic [11:0]        port_speed;
        logic [9:0]         packet_length;
        logic [8:0]         id_skip;
        t_phase             phase;
        logic [7:0]         last_sample;
        logic signed [15:0] bit_timer;
        logic signed [15:0] global_timer;
        logic signed [15:0] kick_delay;
        logic signed [15:0] sched_timer;
        logic               kick_pending;
        logic signed [10:0] triplet_index;
        t_result            expected_results[$];
        int unsigned        mismatches;

        function new();
            port_speed    = 12'd1024;
            packet_length = 10'd512;
            id_skip       = 9'd0;
            phase         = PH_IDLE;
            last_sample   = '0;
            bit_timer     = '0;
            global_timer  = '0;
            kick_delay    = '0;
            sched_timer   = '0;
            kick_pending  = 1'b0;
            triplet_index = '0;
            mismatches    = 0;
        endfunction

        function void load_registers(input int speed, input int len, input int skip);
            port_speed    = 12'(speed);
            packet_length = 10'(len);
            id_skip       = 9'(skip);
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        // Timeout in samples: constant times speed, over 1024
        function logic signed [15:0] scaled(input logic [11:0] k);
            int unsigned prod;
            prod = k * port_speed;
            return 16'(prod >> SCALE_SHIFT);
        endfunction

        // Count down, holding at the floor
        function logic signed [15:0] step_down(input logic signed [15:0] t);
            return (t > TIMER_FLOOR) ? t - 16'sd1 : t;
        endfunction

        // Work out the result of one accepted request
        function void predict_request(input logic op, input logic [7:0] smp);
            t_result    r;
            logic [7:0] prev;
            logic       waiting;
            int         len_cap;
            r = '0;
            waiting = 1'b0;
            if (op == OP_START) begin
                r.trigger_out = 1'b1;
                triplet_index = -$signed({2'b00, id_skip});
                global_timer  = (id_skip != 0) ? scaled(T_GLOBAL) : 16'sd0;
                kick_delay    = (id_skip != 0) ? scaled(T_KICK) : 16'sd0;
                bit_timer     = scaled(T_START);
                kick_pending  = 1'b0;
                sched_timer   = 16'sd0;
                last_sample   = smp;
                phase         = PH_WAIT;
            end else if (phase != PH_IDLE) begin
                prev = last_sample;
                last_sample = smp;
                if (phase == PH_WAIT) begin
                    // Wait for the clock to fall, or for the start timeout
                    bit_timer = step_down(bit_timer);
                    waiting = !(prev[CLOCK_POS] && !smp[CLOCK_POS]) && bit_timer > 0;
                    if (!waiting) begin
                        if (bit_timer > 0) begin
                            bit_timer = scaled(T_STROBE);
                        end
                        phase = PH_DATA;
                    end
                end else begin
                    global_timer = step_down(global_timer);
                    bit_timer    = step_down(bit_timer);
                    sched_timer  = step_down(sched_timer);
                    // Rising clock inside the strobe window: take one triplet
                    if (!prev[CLOCK_POS] && smp[CLOCK_POS] && bit_timer > 0) begin
                        if (triplet_index >= 0) begin
                            r.store_valid   = 1'b1;
                            r.store_index   = triplet_index[8:0];
                            r.store_triplet = smp[7:5];
                        end
                        triplet_index = triplet_index + 11'sd1;
                        bit_timer = scaled(T_STROBE);
                    end
                    // First falling axis edge in ID mode arms the second trigger
                    if (kick_delay != 0 && prev[AXIS_POS] && !smp[AXIS_POS]) begin
                        sched_timer  = kick_delay;
                        kick_delay   = 16'sd0;
                        kick_pending = 1'b1;
                    end
                    if (kick_pending && sched_timer < 0 && triplet_index > -END_MARGIN) begin
                        r.trigger_out = 1'b1;
                        bit_timer     = scaled(T_START);
                        kick_pending  = 1'b0;
                        global_timer  = 16'sd0;
                    end
                end
                len_cap = (packet_length > MAX_TRIPLETS) ? MAX_TRIPLETS : int'(packet_length);
                if (!waiting &&
                    !((global_timer > 0 || bit_timer > 0) && triplet_index < len_cap)) begin
                    r.finished      = 1'b1;
                    r.bits_received = triplet_index;
                    phase           = PH_IDLE;
                end
            end
            expected_results.push_back(r);
        endfunction

        function void compare(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        // Check one accepted result against the oldest expectation
        function void check_result(input logic [31:0] data);
            t_result exp_r;
            t_result got;
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: tdata %h", data);
                mismatches++;
                return;
            end
            exp_r = expected_results.pop_front();
            got = t_result'(data[$bits(t_result)-1:0]);
            compare("trigger_out", exp_r.trigger_out, got.trigger_out);
            compare("store_valid", exp_r.store_valid, got.store_valid);
            compare("store_index", exp_r.store_index, got.store_index);
            compare("store_triplet", exp_r.store_triplet, got.store_triplet);
            compare("finished", exp_r.finished, got.finished);
            compare("bits_received", exp_r.bits_received, got.bits_received);
            compare("tdata padding", 0, data[31:$bits(t_result)]);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = REG_PORT_SPEED;
    logic [11:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = OP_SAMPLE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    triplet_read_scoreboard sb = new();
    int snd_idle_pct = 27;
    int rcv_idle_pct = 50;
    int items_sent = 0;

    gameport_triplet_packet_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] port_sample
        .s_axis_tuser  (s_axis_tuser),   // [0] operation
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [0] trigger_out, [1] store_valid,
                                         // [10:2] store_index, [13:11] store_triplet,
                                         // [14] finished, [25:15] bits_received
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Note accepted requests, check accepted results, stall the result side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.predict_request(s_axis_tuser, s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Offer one request; valid stays high afterwards unless the next one idles first
    task automatic send_item(input logic op, input logic [7:0] smp);
        if (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Hold off the sender until every result is back, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input int speed, input int len, input int skip);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_PORT_SPEED;
        i_cfg_data  <= 12'(speed);
        @(posedge i_clk);
        i_cfg_index <= REG_PACKET_LENGTH;
        i_cfg_data  <= 12'(len);
        @(posedge i_clk);
        i_cfg_index <= REG_ID_SKIP;
        i_cfg_data  <= 12'(skip);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.load_registers(speed, len, skip);
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] port_byte(input logic clk_bit, input logic axis_bit);
        logic [7:0] b;
        b = 8'($urandom);
        b[CLOCK_POS] = clk_bit;
        b[AXIS_POS]  = axis_bit;
        return b;
    endfunction

    // Well-formed read: start, falling clock, then clocked triplets with random data
    task automatic send_packet(input int n_trip, input int max_gap);
        int   kick_at;
        logic axis;
        kick_at = $urandom_range(0, n_trip + 2);
        axis = 1'b1;
        send_item(OP_START, port_byte(1'b1, axis));
        repeat ($urandom_range(0, 2)) send_item(OP_SAMPLE, port_byte(1'b1, axis));
        send_item(OP_SAMPLE, port_byte(1'b0, axis));
        for (int i = 0; i < n_trip; i++) begin
            if (i == kick_at) begin
                axis = 1'b0;
            end
            repeat ($urandom_range(0, max_gap)) send_item(OP_SAMPLE, port_byte(1'b0, axis));
            send_item(OP_SAMPLE, port_byte(1'b1, axis));
            repeat ($urandom_range(0, max_gap)) send_item(OP_SAMPLE, port_byte(1'b1, axis));
            send_item(OP_SAMPLE, port_byte(1'b0, axis));
        end
        // Quiet tail, long enough now and then to run the timeouts out
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 60)) send_item(OP_SAMPLE, port_byte(1'b0, axis));
        end
    endtask

    task automatic send_noise(input int n);
        repeat (n) begin
            send_item(($urandom_range(0, 9) == 0) ? OP_START : OP_SAMPLE, 8'($urandom));
        end
    endtask

    initial begin
        int seg_end;
        int speed;
        int len;
        int skip;
        int pick;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample while idle is ignored
        send_item(OP_SAMPLE, 8'hFF);
        // Plain data read at reset settings, then abandoned by a new start
        send_item(OP_START, 8'h10);
        send_item(OP_SAMPLE, 8'h00);
        send_item(OP_SAMPLE, 8'hF0);
        send_item(OP_SAMPLE, 8'h0F);
        send_item(OP_SAMPLE, 8'h10);
        send_item(OP_START, 8'hEF);
        send_item(OP_SAMPLE, 8'hFF);
        send_item(OP_SAMPLE, 8'h00);
        send_item(OP_SAMPLE, 8'h50);
        // Zero timeouts in ID mode: ends at once with a negative count
        drain();
        write_config(0, 1, 5);
        send_item(OP_START, 8'h10);
        send_item(OP_SAMPLE, 8'h00);
        // Zero packet length ends on the first falling clock
        drain();
        write_config(1024, 0, 0);
        send_item(OP_START, 8'h13);
        send_item(OP_SAMPLE, 8'h13);
        send_item(OP_SAMPLE, 8'h03);
        // ID read: skipped triplets, axis fall, second trigger, end on length
        drain();
        write_config(90, 4, 2);
        send_item(OP_START, 8'h11);
        send_item(OP_SAMPLE, 8'h01);
        send_item(OP_SAMPLE, 8'hF1);
        send_item(OP_SAMPLE, 8'hE0);
        send_item(OP_SAMPLE, 8'h30);
        send_item(OP_SAMPLE, 8'h00);
        send_item(OP_SAMPLE, 8'h70);
        send_item(OP_SAMPLE, 8'h00);
        send_item(OP_SAMPLE, 8'h90);
        send_item(OP_SAMPLE, 8'h00);
        send_item(OP_SAMPLE, 8'hD0);
        send_item(OP_SAMPLE, 8'h00);
        send_item(OP_SAMPLE, 8'h30);

        // Random reads under a fresh setting per segment
        for (int seg = 0; seg < 12; seg++) begin
            drain();
            snd_idle_pct = (seg < 4) ? 27 : (seg < 8) ? 50 : 0;
            rcv_idle_pct = (seg < 4) ? 50 : (seg < 8) ? 27 : 0;
            if (seg == 0) begin
                // Length above the buffer size with a long run of triplets
                write_config(4095, 1023, 0);
                send_packet(120, 0);
            end else if (seg == 1) begin
                write_config(4095, 512, 511);
            end else if (seg == 2) begin
                write_config(1, 1, 1);
            end else begin
                pick  = $urandom_range(0, 3);
                speed = (pick == 0) ? $urandom_range(0, 4095) : $urandom_range(60, 1500);
                pick  = $urandom_range(0, 9);
                len   = (pick == 0) ? 0 : (pick < 3) ? $urandom_range(0, 1023)
                                                     : $urandom_range(1, 24);
                pick  = $urandom_range(0, 9);
                skip  = (pick < 5) ? 0 : (pick < 9) ? $urandom_range(1, 12)
                                                    : $urandom_range(0, 511);
                write_config(speed, len, skip);
            end
            seg_end = items_sent + 30;
            while (items_sent < seg_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_packet($urandom_range(0, 16), 1);
                end else if (pick < 85) begin
                    send_noise($urandom_range(1, 8));
                end else begin
                    // Broken read: start followed by arbitrary samples
                    send_item(OP_START, 8'($urandom));
                    send_noise($urandom_range(1, 5));
                end
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Give up on a hung handshake
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
hdl/gptpr_pkg.sv
hdl/gptpr_cfg.sv
hdl/gptpr_core.sv
hdl/gameport_triplet_packet_receiver.sv
test/tb_gameport_triplet_packet_receiver.sv
